// ===== src/point_in_polygon_test_defines.svh =====
// ---------------------------------------------------------------------------
// point_in_polygon_test_defines
// Assertion macros shared by the point-in-polygon RTL.
// ---------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH
`ifndef SYNTH
`define PIP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PIP_ASSERT(lbl, prop, msg)
`define PIP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/pip_pkg.sv =====
// ---------------------------------------------------------------------------
// pip_pkg
// Sizes, command codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_WIDTH  = 16;
  localparam int IN_W         = 16;
  localparam int CMD_W        = 2;
  localparam int OUT_CNT_W    = 7;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W       = COORD_WIDTH + 1;
  localparam int PROD_W       = 2 * DIFF_W;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic [CNT_W-1:0]              cnt_t;

  localparam cnt_t MAX_CNT = cnt_t'(MAX_VERTICES);

  typedef struct packed {
    logic clear;
    logic append;
    logic start;
    logic rd_en;
    idx_t rd_addr;
    logic close;
    logic load_out;
  } pip_cmd_t;

  typedef struct packed {
    cnt_t vcount;
    logic busy;
    logic out_free;
  } pip_sts_t;

endpackage

// ===== src/pip_dp.sv =====
// ---------------------------------------------------------------------------
// pip_dp
// Vertex memory, edge walk pipeline (diff, multiply, compare), crossing
// counter, overflow flag and the result register.
// ---------------------------------------------------------------------------
`include "point_in_polygon_test_defines.svh"

module pip_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic signed [pip_pkg::IN_W-1:0]        in_coord_x,
  input  logic signed [pip_pkg::IN_W-1:0]        in_coord_y,
  input  pip_pkg::pip_cmd_t                      cmd,
  output pip_pkg::pip_sts_t                      sts,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic                                   out_inside_res,
  output logic [pip_pkg::OUT_CNT_W-1:0]          out_crossings,
  output logic                                   out_overflow
);

  pip_pkg::coord_t cx, cy;
  pip_pkg::coord_t mem_x [pip_pkg::MAX_VERTICES];
  pip_pkg::coord_t mem_y [pip_pkg::MAX_VERTICES];

  pip_pkg::cnt_t   vcount_r, vcount_nxt;
  logic            ovf_r, ovf_nxt;
  logic            full;

  pip_pkg::coord_t rd_x_r, rd_y_r;
  logic            rvalid_r, rfirst_r, close_r;
  pip_pkg::coord_t first_x_r, first_y_r, prev_x_r, prev_y_r, px_r, py_r;
  pip_pkg::coord_t cur_x, cur_y;
  logic            ev, straddle;

  pip_pkg::diff_t  a_r, b_r, c_r, dy_r;
  logic            s1_v_r;
  pip_pkg::prod_t  lhs_r, rhs_r;
  logic            s2_v_r, s2_dpos_r;
  logic            hit;
  pip_pkg::cnt_t   count_r;

  logic                          out_valid_r;
  logic                          out_inside_r, out_ovf_r;
  logic [pip_pkg::OUT_CNT_W-1:0] out_cnt_r;

  assign cx   = pip_pkg::coord_t'(in_coord_x);
  assign cy   = pip_pkg::coord_t'(in_coord_y);
  assign full = (vcount_r == pip_pkg::MAX_CNT);

  // vertex table bookkeeping
  always_comb begin
    vcount_nxt = vcount_r;
    ovf_nxt    = ovf_r;
    if (cmd.clear) begin
      vcount_nxt = '0;
      ovf_nxt    = 1'b0;
    end else if (cmd.append) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        vcount_nxt = vcount_r + pip_pkg::cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
      ovf_r    <= 1'b0;
    end else begin
      vcount_r <= vcount_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      mem_x[vcount_r[pip_pkg::IDX_W-1:0]] <= cx;
      mem_y[vcount_r[pip_pkg::IDX_W-1:0]] <= cy;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_x_r <= mem_x[cmd.rd_addr];
      rd_y_r <= mem_y[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvalid_r <= 1'b0;
      rfirst_r <= 1'b0;
      close_r  <= 1'b0;
    end else begin
      rvalid_r <= cmd.rd_en;
      rfirst_r <= cmd.rd_en && (cmd.rd_addr == '0);
      close_r  <= cmd.close;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px_r <= cx;
      py_r <= cy;
    end
    if (rvalid_r) begin
      prev_x_r <= rd_x_r;
      prev_y_r <= rd_y_r;
      if (rfirst_r) begin
        first_x_r <= rd_x_r;
        first_y_r <= rd_y_r;
      end
    end
  end

  // closing edge runs from the last vertex back to the first
  assign ev       = (rvalid_r && !rfirst_r) || close_r;
  assign cur_x    = close_r ? first_x_r : rd_x_r;
  assign cur_y    = close_r ? first_y_r : rd_y_r;
  assign straddle = ((prev_y_r <= py_r) && (cur_y > py_r)) ||
                    ((prev_y_r > py_r) && (cur_y <= py_r));

  always_ff @(posedge clk) begin
    a_r  <= pip_pkg::diff_t'(py_r)  - pip_pkg::diff_t'(prev_y_r);
    b_r  <= pip_pkg::diff_t'(cur_x) - pip_pkg::diff_t'(prev_x_r);
    c_r  <= pip_pkg::diff_t'(px_r)  - pip_pkg::diff_t'(prev_x_r);
    dy_r <= pip_pkg::diff_t'(cur_y) - pip_pkg::diff_t'(prev_y_r);
    lhs_r     <= a_r * b_r;
    rhs_r     <= c_r * dy_r;
    s2_dpos_r <= (dy_r > pip_pkg::diff_t'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= ev && straddle;
      s2_v_r <= s1_v_r;
    end
  end

  assign hit = s2_v_r && (s2_dpos_r ? (lhs_r > rhs_r) : (lhs_r < rhs_r));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      count_r <= '0;
    end else if (hit) begin
      count_r <= count_r + pip_pkg::cnt_t'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_inside_r <= count_r[0];
      out_cnt_r    <= pip_pkg::OUT_CNT_W'(count_r);
      out_ovf_r    <= ovf_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;
  assign out_crossings  = out_cnt_r;
  assign out_overflow   = out_ovf_r;

  assign sts.vcount   = vcount_r;
  assign sts.busy     = rvalid_r | close_r | s1_v_r | s2_v_r;
  assign sts.out_free = !out_valid_r || out_ready;

  `PIP_ASSERT(a_vcount_max, vcount_r <= pip_pkg::MAX_CNT, "vertex count above table size")
  `PIP_ASSERT(a_ovf_rise, $rose(ovf_r) |-> ($past(vcount_r) == pip_pkg::MAX_CNT), "overflow set with room left")
  `PIP_ASSERT(a_close_gap, !(close_r && rvalid_r), "closing edge overlaps a vertex read")

endmodule

// ===== src/pip_ctrl.sv =====
// ---------------------------------------------------------------------------
// pip_ctrl
// Command decode and edge walk sequencer for the point-in-polygon block.
// ---------------------------------------------------------------------------
`include "point_in_polygon_test_defines.svh"

module pip_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pip_pkg::CMD_W-1:0]         in_command,
  output pip_pkg::pip_cmd_t                 cmd,
  input  pip_pkg::pip_sts_t                 sts
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_WALK  = 5'b00010,
    ST_CLOSE = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  pip_pkg::idx_t idx_r, idx_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_command)
            pip_pkg::CMD_CLEAR: begin
              cmd.clear = 1'b1;
            end
            pip_pkg::CMD_APPEND: begin
              cmd.append = 1'b1;
            end
            pip_pkg::CMD_QUERY: begin
              cmd.start = 1'b1;
              idx_nxt   = '0;
              state_nxt = (sts.vcount == '0) ? ST_DONE : ST_WALK;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = idx_r;
        if (pip_pkg::cnt_t'(idx_r) + pip_pkg::cnt_t'(1) == sts.vcount) begin
          state_nxt = ST_CLOSE;
        end else begin
          idx_nxt = idx_r + pip_pkg::idx_t'(1);
        end
      end
      ST_CLOSE: begin
        cmd.close = 1'b1;
        state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  `PIP_ASSERT(a_walk_idx, (state_r == ST_WALK) |-> (pip_pkg::cnt_t'(idx_r) < sts.vcount), "walk index past vertex count")
  `PIP_ASSERT_NEXT(a_close_busy, state_r == ST_CLOSE, sts.busy, "pipeline idle right after closing edge")
  `PIP_ASSERT_NEXT(a_empty_query, in_valid && in_ready && (in_command == pip_pkg::CMD_QUERY) && (sts.vcount == '0), state_r == ST_DONE, "empty polygon query not finished at once")

endmodule

// ===== src/point_in_polygon_test.sv =====
// ---------------------------------------------------------------------------
// point_in_polygon_test
// Even-odd ray casting point-in-polygon test on integer vertices.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready): in_command with in_coord_x/in_coord_y.
//   Clear empties the vertex table and the overflow flag, append stores one
//   vertex (dropped and flagged when the table is full), query tests a
//   point. Command code 3 is taken and ignored.
// Output channel (out_valid/out_ready): one item per query with the inside
//   flag, the crossing count and the sticky overflow flag.
// The next item can follow a clear or an append at once.
// A query walks the stored edges, one vertex read per cycle from the vertex
//   memory, then the closing edge through a diff/multiply/compare pipe:
//   the result is presented after the pipe drains, later when the last edge
//   or the closing edge spans the point's row; an empty table skips the walk.
//   Queries run one at a time.
// A finished result waits in the output register; appends and clears are
//   still taken, a further query too; its result waits for that register.
// Reset (rst_n low, synchronous) empties the table, clears overflow and
//   drops any pending result. Vertex memory contents are not cleared.
// ---------------------------------------------------------------------------
module point_in_polygon_test (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pip_pkg::CMD_W-1:0]         in_command,
  input  logic signed [pip_pkg::IN_W-1:0]   in_coord_x,
  input  logic signed [pip_pkg::IN_W-1:0]   in_coord_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_inside_res,
  output logic [pip_pkg::OUT_CNT_W-1:0]     out_crossings,
  output logic                              out_overflow
);

  pip_pkg::pip_cmd_t cmd;
  pip_pkg::pip_sts_t sts;

  pip_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .cmd        (cmd),
    .sts        (sts)
  );

  pip_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_inside_res (out_inside_res),
    .out_crossings  (out_crossings),
    .out_overflow   (out_overflow)
  );

endmodule
